@@ sv/status_led_blink_controller_unit_defines.svh @@
// Assertion macros shared by the blink controller RTL.
`ifndef STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH
`define STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/slbc_pkg.sv @@
// Shared types, register indexes and reset values of the blink controller.
package slbc_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INTERVAL  = 3'd0,
		REG_BLIP      = 3'd1,
		REG_TIMEOUT   = 3'd2,
		REG_LED_MAX   = 3'd3,
		REG_POS_RED   = 3'd4,
		REG_POS_GREEN = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_SLOW = 2'd1,
		MODE_FAST = 2'd2,
		MODE_ON   = 2'd3
	} led_mode_t;

	typedef struct packed {
		logic [6:0]  interval_ticks;
		logic [7:0]  blip_ticks;
		logic [15:0] mode_timeout;
		logic [7:0]  led_max;
		logic [7:0]  pos_red_level;
		logic [7:0]  pos_green_level;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pos_red;
		logic [7:0] pos_green;
		logic [7:0] link_red;
		logic [7:0] mode_blue;
	} led_word_t;

	localparam logic [6:0]  RstInterval = 7'd100;
	localparam logic [7:0]  RstBlip     = 8'd2;
	localparam logic [15:0] RstTimeout  = 16'd1500;
	localparam logic [7:0]  RstLedMax   = 8'd255;
	localparam logic [7:0]  RstPosRed   = 8'd207;
	localparam logic [7:0]  RstPosGreen = 8'd148;

endpackage

@@ sv/slbc_cfg_regs.sv @@
// Configuration register file of the blink controller.
module slbc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [slbc_pkg::CfgIdxW-1:0] wr_index,
	input  logic [15:0]                 wr_data,
	output slbc_pkg::cfg_t              cfg
);

	slbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ticks  <= slbc_pkg::RstInterval;
			cfg_q.blip_ticks      <= slbc_pkg::RstBlip;
			cfg_q.mode_timeout    <= slbc_pkg::RstTimeout;
			cfg_q.led_max         <= slbc_pkg::RstLedMax;
			cfg_q.pos_red_level   <= slbc_pkg::RstPosRed;
			cfg_q.pos_green_level <= slbc_pkg::RstPosGreen;
		end else if (wr_en) begin
			case (slbc_pkg::cfg_reg_t'(wr_index))
				slbc_pkg::REG_INTERVAL:  cfg_q.interval_ticks  <= wr_data[6:0];
				slbc_pkg::REG_BLIP:      cfg_q.blip_ticks      <= wr_data[7:0];
				slbc_pkg::REG_TIMEOUT:   cfg_q.mode_timeout    <= wr_data;
				slbc_pkg::REG_LED_MAX:   cfg_q.led_max         <= wr_data[7:0];
				slbc_pkg::REG_POS_RED:   cfg_q.pos_red_level   <= wr_data[7:0];
				slbc_pkg::REG_POS_GREEN: cfg_q.pos_green_level <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/slbc_blinker.sv @@
// One blinking indicator: phase counter and latched period.
module slbc_blinker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       relatch,
	input  logic [7:0] new_period,
	output logic       lit
);

	logic [7:0] phase_q;
	logic [7:0] period_q;
	logic [7:0] phase_base;
	logic [7:0] period_n;
	logic [7:0] phase_inc;
	logic [7:0] phase_n;

	always_comb begin
		phase_base = relatch ? 8'hFF : phase_q;
		period_n   = relatch ? new_period : period_q;
		phase_inc  = phase_base + 8'd1;
		phase_n    = (phase_inc >= period_n) ? 8'd0 : phase_inc;
		lit        = (phase_n >= {1'b0, period_n[7:1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 8'hFF;
			period_q <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			period_q <= period_n;
		end
	end

endmodule

@@ sv/slbc_core.sv @@
// Tick counter, mode selection, link countdown and LED level selection.
module slbc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  slbc_pkg::cfg_t       cfg,
	input  logic                 ant_connected,
	input  logic                 pvt_seen,
	input  logic [15:0]          pvt_age,
	input  logic [7:0]           tracked_sigs,
	input  logic [7:0]           base_obs_count,
	input  logic                 dgnss_seen,
	input  logic [15:0]          dgnss_age,
	input  logic                 dgnss_fixed,
	output slbc_pkg::led_word_t  result
);

	function automatic logic [7:0] period_for(input slbc_pkg::led_mode_t mode,
	                                          input logic [6:0] interval);
		logic [7:0] p;
		case (mode)
			slbc_pkg::MODE_OFF:  p = {interval, 1'b0};
			slbc_pkg::MODE_SLOW: p = {1'b0, interval};
			slbc_pkg::MODE_FAST: p = {2'b00, interval[6:1]};
			slbc_pkg::MODE_ON:   p = 8'd0;
			default:             p = 8'd0;
		endcase
		return p;
	endfunction

	logic [7:0] tick_q;
	logic [7:0] last_obs_q;
	logic [7:0] blip_q;

	logic                relatch;
	slbc_pkg::led_mode_t pos_mode;
	slbc_pkg::led_mode_t dg_mode;
	logic [7:0]          pos_period;
	logic [7:0]          dg_period;
	logic                pos_lit;
	logic                mode_lit;
	logic                obs_new;
	logic [7:0]          blip_base;
	logic [7:0]          blip_n;
	logic                link_lit;
	logic [7:0]          tick_inc;
	logic [7:0]          tick_n;

	always_comb begin
		relatch = (tick_q == 8'd0);

		if (!ant_connected) begin
			pos_mode = slbc_pkg::MODE_OFF;
		end else if (pvt_seen && (pvt_age < cfg.mode_timeout)) begin
			pos_mode = slbc_pkg::MODE_ON;
		end else if (tracked_sigs != 8'd0) begin
			pos_mode = slbc_pkg::MODE_FAST;
		end else begin
			pos_mode = slbc_pkg::MODE_SLOW;
		end

		if (!dgnss_seen || (dgnss_age >= cfg.mode_timeout)) begin
			dg_mode = slbc_pkg::MODE_OFF;
		end else if (dgnss_fixed) begin
			dg_mode = slbc_pkg::MODE_ON;
		end else begin
			dg_mode = slbc_pkg::MODE_SLOW;
		end

		pos_period = period_for(pos_mode, cfg.interval_ticks);
		dg_period  = period_for(dg_mode, cfg.interval_ticks);

		obs_new   = (base_obs_count != last_obs_q);
		blip_base = obs_new ? cfg.blip_ticks : blip_q;
		blip_n    = (blip_base != 8'd0) ? (blip_base - 8'd1) : 8'd0;
		link_lit  = (blip_n != 8'd0);

		tick_inc = tick_q + 8'd1;
		tick_n   = (tick_inc >= {1'b0, cfg.interval_ticks}) ? 8'd0 : tick_inc;
	end

	slbc_blinker u_pos_blink (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.relatch    (relatch),
		.new_period (pos_period),
		.lit        (pos_lit)
	);

	slbc_blinker u_mode_blink (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.relatch    (relatch),
		.new_period (dg_period),
		.lit        (mode_lit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= 8'd0;
			last_obs_q <= 8'd0;
			blip_q     <= 8'd0;
		end else if (step) begin
			tick_q     <= tick_n;
			last_obs_q <= base_obs_count;
			blip_q     <= blip_n;
		end
	end

	always_comb begin
		result.pos_red   = pos_lit  ? cfg.pos_red_level   : 8'd0;
		result.pos_green = pos_lit  ? cfg.pos_green_level : 8'd0;
		result.link_red  = link_lit ? cfg.led_max         : 8'd0;
		result.mode_blue = mode_lit ? cfg.led_max         : 8'd0;
	end

endmodule

@@ sv/slbc_out_buf.sv @@
// Output register with one skid entry for the result word.
module slbc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  slbc_pkg::led_word_t  push_word,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output slbc_pkg::led_word_t  out_word
);

	logic                valid_q;
	logic                skid_full_q;
	slbc_pkg::led_word_t word_q;
	slbc_pkg::led_word_t skid_q;
	logic                pop;

	assign pop = valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (pop) begin
				skid_full_q <= 1'b0;
			end
		end else if (push) begin
			if (!valid_q || pop) begin
				valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (pop) begin
				word_q <= skid_q;
			end
		end else if (push) begin
			if (!valid_q || pop) begin
				word_q <= push_word;
			end else begin
				skid_q <= push_word;
			end
		end
	end

	assign full      = skid_full_q;
	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

@@ sv/status_led_blink_controller_unit.sv @@
// A result word is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one tick per cycle while in_stall is low; the blinkers and link countdown update in one pass.
// A skid entry lets one more tick in while a result is stalled.
// Reset (arst_n low, asynchronous) restores default registers, clears the
// tick counter and countdown, and sets both blinkers to period zero with phase all ones.
`include "status_led_blink_controller_unit_defines.svh"

module status_led_blink_controller_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [slbc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         ant_connected,
	input  logic                         pvt_seen,
	input  logic [15:0]                  pvt_age,
	input  logic [7:0]                   tracked_sigs,
	input  logic [7:0]                   base_obs_count,
	input  logic                         dgnss_seen,
	input  logic [15:0]                  dgnss_age,
	input  logic                         dgnss_fixed,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   pos_red,
	output logic [7:0]                   pos_green,
	output logic [7:0]                   link_red,
	output logic [7:0]                   mode_blue
);

	slbc_pkg::cfg_t      cfg;
	slbc_pkg::led_word_t result;
	slbc_pkg::led_word_t out_word;
	logic                in_accept;
	logic                buf_full;
	logic                held_accept;

	assign cfg_ready   = 1'b1;
	assign in_stall    = buf_full;
	assign in_accept   = in_valid && !buf_full;
	assign held_accept = in_accept && out_valid && out_stall;

	slbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	slbc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (in_accept),
		.cfg            (cfg),
		.ant_connected  (ant_connected),
		.pvt_seen       (pvt_seen),
		.pvt_age        (pvt_age),
		.tracked_sigs   (tracked_sigs),
		.base_obs_count (base_obs_count),
		.dgnss_seen     (dgnss_seen),
		.dgnss_age      (dgnss_age),
		.dgnss_fixed    (dgnss_fixed),
		.result         (result)
	);

	slbc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_word (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign pos_red   = out_word.pos_red;
	assign pos_green = out_word.pos_green;
	assign link_red  = out_word.link_red;
	assign mode_blue = out_word.mode_blue;

	`SLBC_ASSERT_IMPL(a_skid_implies_out, clk, arst_n, in_stall, out_valid, "stall with no word")
	`SLBC_ASSERT_NEXT(a_accept_gives_out, clk, arst_n, in_accept, out_valid, "no word after tick")
	`SLBC_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n, held_accept, in_stall, "skid not filled")

endmodule

@@ tb/status_led_blink_controller_unit_check.sv @@
`timescale 1ns / 100ps
// Checker that predicts each LED word of the blink controller and compares it with the block.
module status_led_blink_controller_unit_check
	import slbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               ant_connected,
	input  logic               pvt_seen,
	input  logic [15:0]        pvt_age,
	input  logic [7:0]         tracked_sigs,
	input  logic [7:0]         base_obs_count,
	input  logic               dgnss_seen,
	input  logic [15:0]        dgnss_age,
	input  logic               dgnss_fixed,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         pos_red,
	input  logic [7:0]         pos_green,
	input  logic [7:0]         link_red,
	input  logic [7:0]         mode_blue,
	output int                 errors,
	output int                 pending
);

	cfg_t        regs;
	logic [7:0]  tick_count;
	logic [7:0]  pos_phase;
	logic [7:0]  pos_period;
	logic [7:0]  mode_phase;
	logic [7:0]  mode_period;
	logic [7:0]  last_obs;
	logic [7:0]  blip_left;
	led_mode_t   pos_mode;
	led_mode_t   fix_mode;
	logic        pos_lit;
	logic        link_lit;
	logic        mode_lit;
	led_word_t   want;
	led_word_t   got;
	led_word_t   expected_leds[$];

	function automatic logic [7:0] blink_period(led_mode_t m, logic [6:0] interval);
		case (m)
			MODE_OFF:  return {interval, 1'b0};
			MODE_SLOW: return {1'b0, interval};
			MODE_FAST: return {2'b00, interval[6:1]};
			default:   return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] next_phase(logic [7:0] phase, logic [7:0] period);
		logic [7:0] n;
		n = phase + 8'd1;
		return (n >= period) ? 8'd0 : n;
	endfunction

	task automatic check_led(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			errors = errors + 1;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{RstInterval, RstBlip, RstTimeout, RstLedMax, RstPosRed, RstPosGreen};
			tick_count = '0;
			pos_phase = '1;
			pos_period = '0;
			mode_phase = '1;
			mode_period = '0;
			last_obs = '0;
			blip_left = '0;
			expected_leds.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{pos_red, pos_green, link_red, mode_blue};
				if (expected_leds.size() == 0) begin
					errors = errors + 1;
					$display("%0t: LED word with none expected, expected nothing, actual %h",
						$time, got);
				end else begin
					want = expected_leds.pop_front();
					check_led("pos_red", want.pos_red, got.pos_red);
					check_led("pos_green", want.pos_green, got.pos_green);
					check_led("link_red", want.link_red, got.link_red);
					check_led("mode_blue", want.mode_blue, got.mode_blue);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INTERVAL:  regs.interval_ticks = cfg_data[6:0];
					REG_BLIP:      regs.blip_ticks = cfg_data[7:0];
					REG_TIMEOUT:   regs.mode_timeout = cfg_data;
					REG_LED_MAX:   regs.led_max = cfg_data[7:0];
					REG_POS_RED:   regs.pos_red_level = cfg_data[7:0];
					REG_POS_GREEN: regs.pos_green_level = cfg_data[7:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (tick_count == 8'd0) begin
					if (!ant_connected)
						pos_mode = MODE_OFF;
					else if (pvt_seen && pvt_age < regs.mode_timeout)
						pos_mode = MODE_ON;
					else if (tracked_sigs != 8'd0)
						pos_mode = MODE_FAST;
					else
						pos_mode = MODE_SLOW;
					if (!dgnss_seen || dgnss_age >= regs.mode_timeout)
						fix_mode = MODE_OFF;
					else if (dgnss_fixed)
						fix_mode = MODE_ON;
					else
						fix_mode = MODE_SLOW;
					pos_phase = '1;
					pos_period = blink_period(pos_mode, regs.interval_ticks);
					mode_phase = '1;
					mode_period = blink_period(fix_mode, regs.interval_ticks);
				end
				pos_phase = next_phase(pos_phase, pos_period);
				pos_lit = pos_phase >= (pos_period >> 1);

				if (base_obs_count != last_obs) begin
					last_obs = base_obs_count;
					blip_left = regs.blip_ticks;
				end
				if (blip_left != 8'd0)
					blip_left = blip_left - 8'd1;
				link_lit = blip_left != 8'd0;

				mode_phase = next_phase(mode_phase, mode_period);
				mode_lit = mode_phase >= (mode_period >> 1);

				tick_count = tick_count + 8'd1;
				if (tick_count >= {1'b0, regs.interval_ticks})
					tick_count = '0;

				want.pos_red = pos_lit ? regs.pos_red_level : 8'd0;
				want.pos_green = pos_lit ? regs.pos_green_level : 8'd0;
				want.link_red = link_lit ? regs.led_max : 8'd0;
				want.mode_blue = mode_lit ? regs.led_max : 8'd0;
				expected_leds.push_back(want);
			end
			pending <= expected_leds.size();
		end
	end

endmodule

@@ tb/status_led_blink_controller_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the blink controller: clock, reset, stimulus, watchdog and verdict.
module status_led_blink_controller_unit_test;
	import slbc_pkg::*;

	localparam int HalfPeriod = 5;
	localparam int WatchdogLimit = 2000;
	localparam int HoldCycles = 80;
	localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

	typedef struct packed {
		logic        ant_connected;
		logic        pvt_seen;
		logic [15:0] pvt_age;
		logic [7:0]  tracked_sigs;
		logic [7:0]  base_obs_count;
		logic        dgnss_seen;
		logic [15:0] dgnss_age;
		logic        dgnss_fixed;
	} status_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               ant_connected;
	logic               pvt_seen;
	logic [15:0]        pvt_age;
	logic [7:0]         tracked_sigs;
	logic [7:0]         base_obs_count;
	logic               dgnss_seen;
	logic [15:0]        dgnss_age;
	logic               dgnss_fixed;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         pos_red;
	logic [7:0]         pos_green;
	logic [7:0]         link_red;
	logic [7:0]         mode_blue;
	int                 errors;
	int                 pending;

	int          ticks_sent;
	int          words_seen;
	int          settings_used;
	int          idle_cycles;
	int          hold_left;
	int          stall_left;
	bit          hold_req;
	bit          quiet;
	bit          tx_idle_en;
	logic [15:0] cur_timeout;
	logic [7:0]  obs_now;

	status_led_blink_controller_unit u_dut (.*);
	status_led_blink_controller_unit_check u_check (.*);

	initial clk = 1'b0;
	always #HalfPeriod clk = ~clk;

	function automatic status_t make_status(logic ant, logic p_seen, logic [15:0] p_age,
		logic [7:0] sig, logic [7:0] obs, logic d_seen, logic [15:0] d_age, logic d_fixed);
		status_t s;
		s = {ant, p_seen, p_age, sig, obs, d_seen, d_age, d_fixed};
		return s;
	endfunction

	function automatic logic [15:0] pick_age();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(0, 15));
			default: return cur_timeout + 16'($urandom_range(0, 4)) - 16'd2;
		endcase
	endfunction

	function automatic status_t random_status();
		status_t s;
		case ($urandom_range(0, 4))
			0:       obs_now = obs_now + 8'd1;
			1:       obs_now = 8'($urandom);
			default: ;
		endcase
		s.ant_connected = ($urandom_range(0, 9) != 0);
		s.pvt_seen = ($urandom_range(0, 7) != 0);
		s.pvt_age = pick_age();
		s.tracked_sigs = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
		s.base_obs_count = obs_now;
		s.dgnss_seen = ($urandom_range(0, 7) != 0);
		s.dgnss_age = pick_age();
		s.dgnss_fixed = 1'($urandom_range(0, 1));
		return s;
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [6:0] interval, logic [7:0] blip, logic [15:0] timeout,
		logic [7:0] led, logic [7:0] red, logic [7:0] green);
		write_reg(REG_INTERVAL, {9'($urandom), interval});
		write_reg(REG_BLIP, {8'($urandom), blip});
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_LED_MAX, {8'($urandom), led});
		write_reg(REG_POS_RED, {8'($urandom), red});
		write_reg(REG_POS_GREEN, {8'($urandom), green});
		write_reg(($urandom_range(0, 1) != 0) ? RegSpareHi : RegSpareLo, 16'($urandom));
		cur_timeout = timeout;
		settings_used++;
	endtask

	task automatic send_status(status_t s);
		in_valid <= 1'b1;
		{ant_connected, pvt_seen, pvt_age, tracked_sigs, base_obs_count,
			dgnss_seen, dgnss_age, dgnss_fixed} <= s;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		ticks_sent++;
	endtask

	task automatic pause_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_phase(int items, bit with_hold, bit with_pause);
		tx_idle_en = ($urandom_range(0, 2) != 0);
		for (int i = 0; i < items; i++) begin
			if (with_hold && i == 10)
				hold_req = 1'b1;
			if (with_pause && i == items / 2)
				drain();
			send_status(random_status());
			if (tx_idle_en && !quiet && !with_hold && $urandom_range(0, 5) == 0)
				pause_sender($urandom_range(1, 13));
		end
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			words_seen <= words_seen + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_INTERVAL;
		cfg_data = '0;
		in_valid = 1'b0;
		{ant_connected, pvt_seen, pvt_age, tracked_sigs, base_obs_count,
			dgnss_seen, dgnss_age, dgnss_fixed} = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		quiet = 1'b0;
		tx_idle_en = 1'b0;
		hold_left = 0;
		stall_left = 0;
		ticks_sent = 0;
		words_seen = 0;
		settings_used = 1;
		idle_cycles = 0;
		cur_timeout = RstTimeout;
		obs_now = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: steady position and fixed mode, then link blips both ways.
		send_status(make_status(1, 1, 16'd0, 8'd0, 8'd0, 1, 16'd0, 1));
		send_status(make_status(1, 1, 16'hFFFF, 8'hFF, 8'hFF, 1, 16'hFFFF, 1));
		send_status(make_status(0, 0, 16'd0, 8'd0, 8'd0, 0, 16'd0, 0));
		drain();

		// Interval of zero: every tick latches a new mode.
		configure(7'd0, 8'd2, 16'd1500, 8'd255, 8'd207, 8'd148);
		send_status(make_status(0, 0, 16'd0, 8'd0, 8'd0, 0, 16'd0, 0));
		send_status(make_status(1, 0, 16'd0, 8'd0, 8'd1, 1, 16'd1499, 0));
		send_status(make_status(1, 0, 16'd0, 8'h80, 8'd1, 1, 16'd1500, 1));
		send_status(make_status(1, 1, 16'd1499, 8'd0, 8'd2, 1, 16'd0, 1));
		send_status(make_status(1, 1, 16'd1500, 8'd0, 8'd2, 0, 16'd0, 1));
		drain();

		// Interval of one, so the fast period is zero.
		configure(7'd1, 8'd1, 16'd0, 8'd0, 8'hFF, 8'h00);
		send_status(make_status(1, 1, 16'd0, 8'd7, 8'd3, 1, 16'd0, 1));
		send_status(make_status(1, 0, 16'd0, 8'd0, 8'd4, 1, 16'd0, 0));
		send_status(make_status(1, 1, 16'd0, 8'd1, 8'd4, 0, 16'd0, 0));
		drain();

		configure(7'd20, 8'd255, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
		for (int i = 0; i < 8; i++)
			send_status(make_status(1, 1, 16'hFFFE, 8'd3, 8'(i + 9), 1, 16'hFFFF, 1));
		drain();

		// Interval lowered below the running counter.
		write_reg(REG_INTERVAL, 16'd3);
		for (int i = 0; i < 3; i++)
			send_status(make_status(1, 0, 16'd0, 8'd0, 8'd16, 1, 16'd5, 0));
		drain();

		for (int p = 0; p < 10; p++) begin
			quiet = (p >= 8);
			case (p)
				0: configure(7'd1, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
				1: configure(7'd127, 8'd255, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
				default: configure(7'($urandom_range(1, 10)), 8'($urandom_range(0, 8)),
					16'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			random_phase((p == 1) ? 150 : 60, p == 3, p == 5);
		end

		$display("Drove %0d status ticks over %0d register settings, intervals 0 to 127,",
			ticks_sent, settings_used);
		$display("and checked %0d LED words, with a long output hold-off and a mid-run drain.",
			words_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/slbc_pkg.sv
sv/slbc_cfg_regs.sv
sv/slbc_blinker.sv
sv/slbc_core.sv
sv/slbc_out_buf.sv
sv/status_led_blink_controller_unit.sv
tb/status_led_blink_controller_unit_check.sv
tb/status_led_blink_controller_unit_test.sv
